// ===== hdl/gss_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// gss_pkg
// Shared types, codes and sequencing functions of the gear shift sequencer.
// ----------------------------------------------------------------------------
package gss_pkg;

    localparam int unsigned TIME_W  = 10;
    localparam int unsigned PEND_W  = 8;
    localparam int unsigned RPM_W   = 16;
    localparam int unsigned CMD_W   = 3;
    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned ADDR_W  = 5;
    localparam int unsigned DATA_W  = 32;
    localparam int unsigned THR_W   = 17;

    // commands
    localparam logic [CMD_W-1:0] CMD_TICK    = 3'd0;
    localparam logic [CMD_W-1:0] CMD_UP      = 3'd1;
    localparam logic [CMD_W-1:0] CMD_DOWN    = 3'd2;
    localparam logic [CMD_W-1:0] CMD_NEUTRAL = 3'd3;
    localparam logic [CMD_W-1:0] CMD_FRAME   = 3'd4;

    // register indexes
    localparam logic [2:0] REG_UP_HOLD    = 3'd0;
    localparam logic [2:0] REG_DN_LEAD    = 3'd1;
    localparam logic [2:0] REG_DN_HOLD    = 3'd2;
    localparam logic [2:0] REG_DN_TRAIL   = 3'd3;
    localparam logic [2:0] REG_POST_DELAY = 3'd4;
    localparam logic [2:0] REG_NEUT_EXT   = 3'd5;
    localparam logic [2:0] REG_AUTO_THR   = 3'd6;
    localparam logic [2:0] REG_ACCEL      = 3'd7;

    // up phases
    localparam logic [1:0] UP_IDLE = 2'd0;
    localparam logic [1:0] UP_HOLD = 2'd1;
    localparam logic [1:0] UP_EXT  = 2'd2;

    // down phases
    localparam logic [2:0] DN_IDLE  = 3'd0;
    localparam logic [2:0] DN_LEAD  = 3'd1;
    localparam logic [2:0] DN_HOLD  = 3'd2;
    localparam logic [2:0] DN_EXT   = 3'd3;
    localparam logic [2:0] DN_TRAIL = 3'd4;
    localparam logic [2:0] DN_POST  = 3'd5;

    localparam logic [BYTE_W-1:0] FRAME_TAG0 = 8'h82;
    localparam logic [BYTE_W-1:0] FRAME_TAG1 = 8'h81;
    localparam logic [BYTE_W-1:0] FRAME_TAG2 = 8'h80;

    localparam logic [RPM_W-1:0] RPM_LOW_LIMIT  = 16'd100;
    localparam logic [RPM_W-1:0] RPM_HIGH_LIMIT = 16'd500;
    localparam logic [THR_W-1:0] RPM_SCALE      = 17'd100;
    localparam logic [PEND_W-1:0] PEND_MAX      = 8'd255;

    localparam logic [TIME_W-1:0] RST_UP_HOLD    = 10'd200;
    localparam logic [TIME_W-1:0] RST_DN_LEAD    = 10'd30;
    localparam logic [TIME_W-1:0] RST_DN_HOLD    = 10'd150;
    localparam logic [TIME_W-1:0] RST_DN_TRAIL   = 10'd30;
    localparam logic [TIME_W-1:0] RST_POST_DELAY = 10'd100;
    localparam logic [TIME_W-1:0] RST_NEUT_EXT   = 10'd50;
    localparam logic [TIME_W-1:0] RST_AUTO_THR   = 10'd20;

    typedef struct packed {
        logic [TIME_W-1:0] up_hold_time;
        logic [TIME_W-1:0] down_clutch_lead;
        logic [TIME_W-1:0] down_hold_time;
        logic [TIME_W-1:0] down_clutch_trail;
        logic [TIME_W-1:0] post_shift_delay;
        logic [TIME_W-1:0] neutral_extend_time;
        logic [TIME_W-1:0] auto_up_rpm_hundreds;
        logic              accel_mode;
    } t_cfg;

    typedef struct packed {
        logic             up_solenoid;
        logic             down_solenoid;
        logic             clutch_valve;
        logic             up_lamp;
        logic             down_lamp;
        logic             shift_refused;
        logic             auto_up_fired;
        logic [RPM_W-1:0] engine_rpm;
    } t_res;

    typedef struct packed {
        logic [1:0]        phase;
        logic [TIME_W-1:0] timer;
        logic              take;
    } t_up_step;

    typedef struct packed {
        logic [2:0]        phase;
        logic [TIME_W-1:0] timer;
        logic              take;
    } t_dn_step;

    // end of an up phase whose timer has run out
    function automatic t_up_step up_finish(input logic [1:0] phase,
                                           input logic pend_nz,
                                           input t_cfg cfg);
        t_up_step s;
        s.phase = UP_IDLE;
        s.timer = '0;
        s.take  = 1'b0;
        if (phase == UP_HOLD && pend_nz) begin
            s.take = 1'b1;
            if (cfg.neutral_extend_time != '0) begin
                s.phase = UP_EXT;
                s.timer = cfg.neutral_extend_time;
            end
        end
        return s;
    endfunction

    // walks down phases until one with a nonzero time, at most five steps
    function automatic t_dn_step dn_finish(input logic [2:0] phase,
                                           input logic pend_nz,
                                           input t_cfg cfg);
        t_dn_step s;
        logic     done;
        s.phase = phase;
        s.timer = '0;
        s.take  = 1'b0;
        done    = 1'b0;
        for (int i = 0; i < 5; i++) begin
            if (!done) begin
                case (s.phase)
                    DN_LEAD: begin
                        s.phase = DN_HOLD;
                        s.timer = cfg.down_hold_time;
                    end
                    DN_HOLD: begin
                        if (pend_nz) begin
                            s.take  = 1'b1;
                            s.phase = DN_EXT;
                            s.timer = cfg.neutral_extend_time;
                        end else begin
                            s.phase = DN_TRAIL;
                            s.timer = cfg.down_clutch_trail;
                        end
                    end
                    DN_EXT: begin
                        s.phase = DN_TRAIL;
                        s.timer = cfg.down_clutch_trail;
                    end
                    DN_TRAIL: begin
                        s.phase = DN_POST;
                        s.timer = cfg.post_shift_delay;
                    end
                    default: begin
                        s.phase = DN_IDLE;
                        s.timer = '0;
                        done    = 1'b1;
                    end
                endcase
                if (s.timer != '0) begin
                    done = 1'b1;
                end
            end
        end
        return s;
    endfunction

endpackage
`default_nettype wire

// ===== hdl/gear_shift_sequencer.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// gear_shift_sequencer
// Event driven up/down gearshift actuator sequencer with APB register port.
// ----------------------------------------------------------------------------
// Takes one word per clock cycle while o_ready is high (tick, up, down, neutral
// or engine frame) and returns one result word per input word, the actuator
// levels after that event. The whole update is one pass of logic into the
// state and result registers (the skid register when the output stalls). A
// two-entry output buffer (result register plus skid register) keeps o_ready
// high for one stalled result; input stalls only when both entries are full.
module gear_shift_sequencer (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_valid,
    output logic                                o_ready,
    input  wire logic [gss_pkg::CMD_W-1:0]      i_command,
    input  wire logic [gss_pkg::BYTE_W-1:0]     i_frame_tag0,
    input  wire logic [gss_pkg::BYTE_W-1:0]     i_frame_tag1,
    input  wire logic [gss_pkg::BYTE_W-1:0]     i_frame_tag2,
    input  wire logic [gss_pkg::BYTE_W-1:0]     i_rpm_high_byte,
    input  wire logic [gss_pkg::BYTE_W-1:0]     i_rpm_low_byte,
    output logic                                o_valid,
    input  wire logic                           i_ready,
    output logic                                o_up_solenoid,
    output logic                                o_down_solenoid,
    output logic                                o_clutch_valve,
    output logic                                o_up_lamp,
    output logic                                o_down_lamp,
    output logic                                o_shift_refused,
    output logic                                o_auto_up_fired,
    output logic [gss_pkg::RPM_W-1:0]           o_engine_rpm,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [gss_pkg::ADDR_W-1:0]     paddr,
    input  wire logic [gss_pkg::DATA_W-1:0]     pwdata,
    output logic [gss_pkg::DATA_W-1:0]          prdata,
    output logic                                pready
);

    gss_pkg::t_cfg                      r_cfg;
    logic [1:0]                         r_up_phase, n_up_phase;
    logic [gss_pkg::TIME_W-1:0]         r_up_timer, n_up_timer;
    logic [2:0]                         r_dn_phase, n_dn_phase;
    logic [gss_pkg::TIME_W-1:0]         r_dn_timer, n_dn_timer;
    logic [gss_pkg::PEND_W-1:0]         r_pend, n_pend;
    logic [gss_pkg::RPM_W-1:0]          r_rpm, n_rpm;
    gss_pkg::t_res                      r_out, r_skd, res;
    logic                               r_out_vld, r_skd_vld;

    logic                               in_acc, out_acc, cfg_wr;
    logic [2:0]                         cfg_idx;
    logic                               frame_ok, fire, up_go, win_ok;
    logic [gss_pkg::RPM_W-1:0]          rpm_new;
    logic [gss_pkg::THR_W-1:0]          thr_rpm;
    logic [gss_pkg::PEND_W-1:0]         pend_mid;
    logic [gss_pkg::TIME_W-1:0]         up_dec, dn_dec;
    gss_pkg::t_up_step                  up_s;
    gss_pkg::t_dn_step                  dn_s;
    logic                               refused;

    assign in_acc  = i_valid && o_ready;
    assign out_acc = r_out_vld && i_ready;
    assign o_ready = !r_skd_vld;
    assign o_valid = r_out_vld;
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = paddr[gss_pkg::ADDR_W-1:2];

    // register port
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.up_hold_time         <= gss_pkg::RST_UP_HOLD;
            r_cfg.down_clutch_lead     <= gss_pkg::RST_DN_LEAD;
            r_cfg.down_hold_time       <= gss_pkg::RST_DN_HOLD;
            r_cfg.down_clutch_trail    <= gss_pkg::RST_DN_TRAIL;
            r_cfg.post_shift_delay     <= gss_pkg::RST_POST_DELAY;
            r_cfg.neutral_extend_time  <= gss_pkg::RST_NEUT_EXT;
            r_cfg.auto_up_rpm_hundreds <= gss_pkg::RST_AUTO_THR;
            r_cfg.accel_mode           <= 1'b0;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                gss_pkg::REG_UP_HOLD:    r_cfg.up_hold_time <= pwdata[9:0];
                gss_pkg::REG_DN_LEAD:    r_cfg.down_clutch_lead <= pwdata[9:0];
                gss_pkg::REG_DN_HOLD:    r_cfg.down_hold_time <= pwdata[9:0];
                gss_pkg::REG_DN_TRAIL:   r_cfg.down_clutch_trail <= pwdata[9:0];
                gss_pkg::REG_POST_DELAY: r_cfg.post_shift_delay <= pwdata[9:0];
                gss_pkg::REG_NEUT_EXT:   r_cfg.neutral_extend_time <= pwdata[9:0];
                gss_pkg::REG_AUTO_THR:   r_cfg.auto_up_rpm_hundreds <= pwdata[9:0];
                gss_pkg::REG_ACCEL:      r_cfg.accel_mode <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        unique case (cfg_idx)
            gss_pkg::REG_UP_HOLD:    prdata = 32'(r_cfg.up_hold_time);
            gss_pkg::REG_DN_LEAD:    prdata = 32'(r_cfg.down_clutch_lead);
            gss_pkg::REG_DN_HOLD:    prdata = 32'(r_cfg.down_hold_time);
            gss_pkg::REG_DN_TRAIL:   prdata = 32'(r_cfg.down_clutch_trail);
            gss_pkg::REG_POST_DELAY: prdata = 32'(r_cfg.post_shift_delay);
            gss_pkg::REG_NEUT_EXT:   prdata = 32'(r_cfg.neutral_extend_time);
            gss_pkg::REG_AUTO_THR:   prdata = 32'(r_cfg.auto_up_rpm_hundreds);
            gss_pkg::REG_ACCEL:      prdata = 32'(r_cfg.accel_mode);
            default:                 prdata = '0;
        endcase
    end

    // event decode
    assign frame_ok = (i_command == gss_pkg::CMD_FRAME) &&
                      (i_frame_tag0 == gss_pkg::FRAME_TAG0) &&
                      (i_frame_tag1 == gss_pkg::FRAME_TAG1) &&
                      (i_frame_tag2 == gss_pkg::FRAME_TAG2);
    assign rpm_new  = frame_ok ? {i_rpm_high_byte, i_rpm_low_byte} : r_rpm;
    assign thr_rpm  = gss_pkg::THR_W'(r_cfg.auto_up_rpm_hundreds) * gss_pkg::RPM_SCALE;
    assign fire     = frame_ok && r_cfg.accel_mode &&
                      (gss_pkg::THR_W'(rpm_new) > thr_rpm);
    assign up_go    = (i_command == gss_pkg::CMD_UP) || fire;
    assign win_ok   = (rpm_new < gss_pkg::RPM_LOW_LIMIT) ||
                      (rpm_new > gss_pkg::RPM_HIGH_LIMIT);
    assign up_dec   = (r_up_timer != '0) ? r_up_timer - 10'd1 : '0;
    assign dn_dec   = (r_dn_timer != '0) ? r_dn_timer - 10'd1 : '0;

    always_comb begin
        n_up_phase = r_up_phase;
        n_up_timer = r_up_timer;
        n_dn_phase = r_dn_phase;
        n_dn_timer = r_dn_timer;
        n_pend     = r_pend;
        n_rpm      = rpm_new;
        refused    = 1'b0;
        pend_mid   = r_pend;
        up_s       = gss_pkg::up_finish(gss_pkg::UP_HOLD, r_pend != '0, r_cfg);
        dn_s       = gss_pkg::dn_finish(gss_pkg::DN_LEAD, r_pend != '0, r_cfg);
        case (i_command)
            gss_pkg::CMD_TICK: begin
                up_s = gss_pkg::up_finish(r_up_phase, r_pend != '0, r_cfg);
                if (r_up_phase != gss_pkg::UP_IDLE) begin
                    if (up_dec == '0) begin
                        n_up_phase = up_s.phase;
                        n_up_timer = up_s.timer;
                        pend_mid   = r_pend - gss_pkg::PEND_W'(up_s.take);
                    end else begin
                        n_up_timer = up_dec;
                    end
                end
                dn_s = gss_pkg::dn_finish(r_dn_phase, pend_mid != '0, r_cfg);
                n_pend = pend_mid;
                if (r_dn_phase != gss_pkg::DN_IDLE) begin
                    if (dn_dec == '0) begin
                        n_dn_phase = dn_s.phase;
                        n_dn_timer = dn_s.timer;
                        n_pend     = pend_mid - gss_pkg::PEND_W'(dn_s.take);
                    end else begin
                        n_dn_timer = dn_dec;
                    end
                end
            end
            gss_pkg::CMD_DOWN: begin
                if (r_dn_phase == gss_pkg::DN_IDLE) begin
                    if (!win_ok) begin
                        refused = 1'b1;
                    end else if (r_cfg.down_clutch_lead != '0) begin
                        n_dn_phase = gss_pkg::DN_LEAD;
                        n_dn_timer = r_cfg.down_clutch_lead;
                    end else begin
                        n_dn_phase = dn_s.phase;
                        n_dn_timer = dn_s.timer;
                        n_pend     = r_pend - gss_pkg::PEND_W'(dn_s.take);
                    end
                end
            end
            gss_pkg::CMD_NEUTRAL: begin
                if (r_pend != gss_pkg::PEND_MAX) begin
                    n_pend = r_pend + 8'd1;
                end
            end
            default: begin
                // up request and engine frame share the up start path
                if (up_go && r_up_phase == gss_pkg::UP_IDLE) begin
                    if (!win_ok) begin
                        refused = 1'b1;
                    end else if (r_cfg.up_hold_time != '0) begin
                        n_up_phase = gss_pkg::UP_HOLD;
                        n_up_timer = r_cfg.up_hold_time;
                    end else begin
                        n_up_phase = up_s.phase;
                        n_up_timer = up_s.timer;
                        n_pend     = r_pend - gss_pkg::PEND_W'(up_s.take);
                    end
                end
            end
        endcase
    end

    always_comb begin
        res.up_solenoid   = (n_up_phase == gss_pkg::UP_HOLD) ||
                            (n_up_phase == gss_pkg::UP_EXT);
        res.down_solenoid = (n_dn_phase == gss_pkg::DN_HOLD) ||
                            (n_dn_phase == gss_pkg::DN_EXT);
        res.clutch_valve  = (n_dn_phase == gss_pkg::DN_LEAD) ||
                            (n_dn_phase == gss_pkg::DN_HOLD) ||
                            (n_dn_phase == gss_pkg::DN_EXT)  ||
                            (n_dn_phase == gss_pkg::DN_TRAIL);
        res.up_lamp       = (n_up_phase != gss_pkg::UP_IDLE);
        res.down_lamp     = (n_dn_phase != gss_pkg::DN_IDLE);
        res.shift_refused = refused;
        res.auto_up_fired = fire;
        res.engine_rpm    = n_rpm;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_up_phase <= gss_pkg::UP_IDLE;
            r_up_timer <= '0;
            r_dn_phase <= gss_pkg::DN_IDLE;
            r_dn_timer <= '0;
            r_pend     <= '0;
            r_rpm      <= '0;
        end else if (in_acc) begin
            r_up_phase <= n_up_phase;
            r_up_timer <= n_up_timer;
            r_dn_phase <= n_dn_phase;
            r_dn_timer <= n_dn_timer;
            r_pend     <= n_pend;
            r_rpm      <= n_rpm;
        end
    end

    // result register plus skid entry
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
            r_skd_vld <= 1'b0;
        end else if (!r_out_vld || out_acc) begin
            if (r_skd_vld) begin
                r_out_vld <= 1'b1;
                r_skd_vld <= 1'b0;
            end else begin
                r_out_vld <= in_acc;
            end
        end else if (in_acc) begin
            r_skd_vld <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_vld || out_acc) begin
            r_out <= r_skd_vld ? r_skd : res;
        end else if (in_acc) begin
            r_skd <= res;
        end
    end

    assign o_up_solenoid   = r_out.up_solenoid;
    assign o_down_solenoid = r_out.down_solenoid;
    assign o_clutch_valve  = r_out.clutch_valve;
    assign o_up_lamp       = r_out.up_lamp;
    assign o_down_lamp     = r_out.down_lamp;
    assign o_shift_refused = r_out.shift_refused;
    assign o_auto_up_fired = r_out.auto_up_fired;
    assign o_engine_rpm    = r_out.engine_rpm;

`ifndef ASSERT_OFF
    a_skid_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skd_vld |-> r_out_vld)
        else $error("skid entry held without result entry");

    a_down_has_clutch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && r_out.down_solenoid) |-> r_out.clutch_valve)
        else $error("down solenoid driven without clutch");

    a_clutch_has_lamp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && r_out.clutch_valve) |-> r_out.down_lamp)
        else $error("clutch driven outside down sequence");

    a_tick_no_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_command == gss_pkg::CMD_TICK) |-> (!res.shift_refused && !res.auto_up_fired))
        else $error("request flags set on a tick");

    a_stall_holds_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !in_acc |=> ($stable(r_up_phase) && $stable(r_dn_phase) && $stable(r_pend)))
        else $error("sequencer state moved without an accepted word");
`endif

endmodule
`default_nettype wire

// ===== tb/tb_gear_shift_sequencer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_gear_shift_sequencer
// Self-checking bench for the gear shift sequencer. Register reset values are
// read back first. Words are sent through the valid/ready input with random
// gaps. A predictor tracks the up and down sequences, the neutral count and
// the stored rpm. Each result word is compared field by field against the
// predicted levels while the output side stalls at random. Timing registers
// are rewritten over the APB port between phases.
// ----------------------------------------------------------------------------
module tb_gear_shift_sequencer;

    localparam int unsigned CYCLE_LIMIT   = 1000000;
    localparam int unsigned SETTLE_CYCLES = 8;
    localparam int unsigned LONG_HOLD     = 150;

    typedef struct packed {
        logic [gss_pkg::CMD_W-1:0]  cmd;
        logic [gss_pkg::BYTE_W-1:0] tag0;
        logic [gss_pkg::BYTE_W-1:0] tag1;
        logic [gss_pkg::BYTE_W-1:0] tag2;
        logic [gss_pkg::BYTE_W-1:0] rpm_hi;
        logic [gss_pkg::BYTE_W-1:0] rpm_lo;
    } t_word;

    logic                        i_clk           = 1'b0;
    logic                        i_rst_n         = 1'b0;
    logic                        i_valid         = 1'b0;
    logic                        o_ready;
    logic [gss_pkg::CMD_W-1:0]   i_command       = gss_pkg::CMD_TICK;
    logic [gss_pkg::BYTE_W-1:0]  i_frame_tag0    = '0;
    logic [gss_pkg::BYTE_W-1:0]  i_frame_tag1    = '0;
    logic [gss_pkg::BYTE_W-1:0]  i_frame_tag2    = '0;
    logic [gss_pkg::BYTE_W-1:0]  i_rpm_high_byte = '0;
    logic [gss_pkg::BYTE_W-1:0]  i_rpm_low_byte  = '0;
    logic                        o_valid;
    logic                        i_ready         = 1'b0;
    logic                        o_up_solenoid;
    logic                        o_down_solenoid;
    logic                        o_clutch_valve;
    logic                        o_up_lamp;
    logic                        o_down_lamp;
    logic                        o_shift_refused;
    logic                        o_auto_up_fired;
    logic [gss_pkg::RPM_W-1:0]   o_engine_rpm;
    logic                        psel            = 1'b0;
    logic                        penable         = 1'b0;
    logic                        pwrite          = 1'b0;
    logic [gss_pkg::ADDR_W-1:0]  paddr           = '0;
    logic [gss_pkg::DATA_W-1:0]  pwdata          = '0;
    logic [gss_pkg::DATA_W-1:0]  prdata;
    logic                        pready;

    // predictor state
    gss_pkg::t_cfg              cfg_m;
    logic [1:0]                 up_ph;
    logic [gss_pkg::TIME_W-1:0] up_tmr;
    logic [2:0]                 dn_ph;
    logic [gss_pkg::TIME_W-1:0] dn_tmr;
    logic [gss_pkg::PEND_W-1:0] neut_cnt;
    logic [gss_pkg::RPM_W-1:0]  rpm_m;
    gss_pkg::t_res              levels_q[$];

    int unsigned errors        = 0;
    int unsigned cycles        = 0;
    int unsigned sink_wait     = 0;
    logic        sink_hold_req = 1'b0;
    logic        no_gaps       = 1'b0;

    gear_shift_sequencer i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_command       (i_command),
        .i_frame_tag0    (i_frame_tag0),
        .i_frame_tag1    (i_frame_tag1),
        .i_frame_tag2    (i_frame_tag2),
        .i_rpm_high_byte (i_rpm_high_byte),
        .i_rpm_low_byte  (i_rpm_low_byte),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_up_solenoid   (o_up_solenoid),
        .o_down_solenoid (o_down_solenoid),
        .o_clutch_valve  (o_clutch_valve),
        .o_up_lamp       (o_up_lamp),
        .o_down_lamp     (o_down_lamp),
        .o_shift_refused (o_shift_refused),
        .o_auto_up_fired (o_auto_up_fired),
        .o_engine_rpm    (o_engine_rpm),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // ---------------- predictor ----------------

    function automatic void shift_model_reset();
        cfg_m.up_hold_time         = gss_pkg::RST_UP_HOLD;
        cfg_m.down_clutch_lead     = gss_pkg::RST_DN_LEAD;
        cfg_m.down_hold_time       = gss_pkg::RST_DN_HOLD;
        cfg_m.down_clutch_trail    = gss_pkg::RST_DN_TRAIL;
        cfg_m.post_shift_delay     = gss_pkg::RST_POST_DELAY;
        cfg_m.neutral_extend_time  = gss_pkg::RST_NEUT_EXT;
        cfg_m.auto_up_rpm_hundreds = gss_pkg::RST_AUTO_THR;
        cfg_m.accel_mode           = 1'b0;
        up_ph    = gss_pkg::UP_IDLE;
        up_tmr   = '0;
        dn_ph    = gss_pkg::DN_IDLE;
        dn_tmr   = '0;
        neut_cnt = '0;
        rpm_m    = '0;
    endfunction

    function automatic logic rpm_in_window();
        return (rpm_m < gss_pkg::RPM_LOW_LIMIT) || (rpm_m > gss_pkg::RPM_HIGH_LIMIT);
    endfunction

    function automatic void up_phase_done();
        if (up_ph == gss_pkg::UP_HOLD && neut_cnt != '0) begin
            neut_cnt = neut_cnt - gss_pkg::PEND_W'(1);
            up_ph    = gss_pkg::UP_EXT;
            up_tmr   = cfg_m.neutral_extend_time;
            if (up_tmr == '0) begin
                up_ph = gss_pkg::UP_IDLE;
            end
        end else begin
            up_ph  = gss_pkg::UP_IDLE;
            up_tmr = '0;
        end
    endfunction

    function automatic void dn_phase_done();
        logic done;
        done = 1'b0;
        while (!done) begin
            case (dn_ph)
                gss_pkg::DN_LEAD: begin
                    dn_ph  = gss_pkg::DN_HOLD;
                    dn_tmr = cfg_m.down_hold_time;
                end
                gss_pkg::DN_HOLD: begin
                    if (neut_cnt != '0) begin
                        neut_cnt = neut_cnt - gss_pkg::PEND_W'(1);
                        dn_ph    = gss_pkg::DN_EXT;
                        dn_tmr   = cfg_m.neutral_extend_time;
                    end else begin
                        dn_ph  = gss_pkg::DN_TRAIL;
                        dn_tmr = cfg_m.down_clutch_trail;
                    end
                end
                gss_pkg::DN_EXT: begin
                    dn_ph  = gss_pkg::DN_TRAIL;
                    dn_tmr = cfg_m.down_clutch_trail;
                end
                gss_pkg::DN_TRAIL: begin
                    dn_ph  = gss_pkg::DN_POST;
                    dn_tmr = cfg_m.post_shift_delay;
                end
                default: begin
                    dn_ph  = gss_pkg::DN_IDLE;
                    dn_tmr = '0;
                    done   = 1'b1;
                end
            endcase
            if (dn_tmr != '0) begin
                done = 1'b1;
            end
        end
    endfunction

    // returns 1 when the rpm window refuses the request
    function automatic logic up_start();
        if (up_ph != gss_pkg::UP_IDLE) begin
            return 1'b0;
        end
        if (!rpm_in_window()) begin
            return 1'b1;
        end
        up_ph  = gss_pkg::UP_HOLD;
        up_tmr = cfg_m.up_hold_time;
        if (up_tmr == '0) begin
            up_phase_done();
        end
        return 1'b0;
    endfunction

    function automatic logic dn_start();
        if (dn_ph != gss_pkg::DN_IDLE) begin
            return 1'b0;
        end
        if (!rpm_in_window()) begin
            return 1'b1;
        end
        dn_ph  = gss_pkg::DN_LEAD;
        dn_tmr = cfg_m.down_clutch_lead;
        if (dn_tmr == '0) begin
            dn_phase_done();
        end
        return 1'b0;
    endfunction

    function automatic void ms_tick();
        if (up_ph != gss_pkg::UP_IDLE) begin
            if (up_tmr != '0) begin
                up_tmr = up_tmr - gss_pkg::TIME_W'(1);
            end
            if (up_tmr == '0) begin
                up_phase_done();
            end
        end
        if (dn_ph != gss_pkg::DN_IDLE) begin
            if (dn_tmr != '0) begin
                dn_tmr = dn_tmr - gss_pkg::TIME_W'(1);
            end
            if (dn_tmr == '0) begin
                dn_phase_done();
            end
        end
    endfunction

    function automatic gss_pkg::t_res shift_levels(input t_word w);
        gss_pkg::t_res r;
        logic          refused;
        logic          fired;
        int unsigned   thr;
        refused = 1'b0;
        fired   = 1'b0;
        thr     = 32'(cfg_m.auto_up_rpm_hundreds) * 32'(gss_pkg::RPM_SCALE);
        case (w.cmd)
            gss_pkg::CMD_TICK:    ms_tick();
            gss_pkg::CMD_UP:      refused = up_start();
            gss_pkg::CMD_DOWN:    refused = dn_start();
            gss_pkg::CMD_NEUTRAL: begin
                if (neut_cnt != gss_pkg::PEND_MAX) begin
                    neut_cnt = neut_cnt + gss_pkg::PEND_W'(1);
                end
            end
            gss_pkg::CMD_FRAME: begin
                if (w.tag0 == gss_pkg::FRAME_TAG0 && w.tag1 == gss_pkg::FRAME_TAG1 &&
                    w.tag2 == gss_pkg::FRAME_TAG2) begin
                    rpm_m = {w.rpm_hi, w.rpm_lo};
                    if (cfg_m.accel_mode && 32'(rpm_m) > thr) begin
                        fired   = 1'b1;
                        refused = up_start();
                    end
                end
            end
            default: ;
        endcase
        r.up_solenoid   = (up_ph == gss_pkg::UP_HOLD) || (up_ph == gss_pkg::UP_EXT);
        r.down_solenoid = (dn_ph == gss_pkg::DN_HOLD) || (dn_ph == gss_pkg::DN_EXT);
        r.clutch_valve  = (dn_ph >= gss_pkg::DN_LEAD) && (dn_ph <= gss_pkg::DN_TRAIL);
        r.up_lamp       = (up_ph != gss_pkg::UP_IDLE);
        r.down_lamp     = (dn_ph != gss_pkg::DN_IDLE);
        r.shift_refused = refused;
        r.auto_up_fired = fired;
        r.engine_rpm    = rpm_m;
        return r;
    endfunction

    // ---------------- words and gaps ----------------

    function automatic int unsigned pick_gap();
        int unsigned r;
        if (no_gaps) begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 55) begin
            return 0;
        end
        if (r < 88) begin
            return $urandom_range(1, 3);
        end
        if (r < 97) begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 40);
    endfunction

    function automatic t_word cmd_word(input logic [gss_pkg::CMD_W-1:0] c);
        t_word w;
        w     = '0;
        w.cmd = c;
        return w;
    endfunction

    function automatic t_word frame_word(input logic [gss_pkg::RPM_W-1:0] rpm);
        t_word w;
        w.cmd             = gss_pkg::CMD_FRAME;
        w.tag0            = gss_pkg::FRAME_TAG0;
        w.tag1            = gss_pkg::FRAME_TAG1;
        w.tag2            = gss_pkg::FRAME_TAG2;
        {w.rpm_hi, w.rpm_lo} = rpm;
        return w;
    endfunction

    function automatic t_word random_word();
        t_word                     w;
        int unsigned               pick;
        logic [gss_pkg::RPM_W-1:0] rpm;
        w.tag0   = 8'($urandom);
        w.tag1   = 8'($urandom);
        w.tag2   = 8'($urandom);
        w.rpm_hi = 8'($urandom);
        w.rpm_lo = 8'($urandom);
        pick     = $urandom_range(0, 99);
        if (pick < 45) begin
            w.cmd = gss_pkg::CMD_TICK;
        end else if (pick < 57) begin
            w.cmd = gss_pkg::CMD_UP;
        end else if (pick < 69) begin
            w.cmd = gss_pkg::CMD_DOWN;
        end else if (pick < 76) begin
            w.cmd = gss_pkg::CMD_NEUTRAL;
        end else if (pick < 96) begin
            case ($urandom_range(0, 3))
                0:       rpm = 16'($urandom_range(0, 99));
                1:       rpm = 16'($urandom_range(100, 500));
                2:       rpm = 16'($urandom_range(501, 3000));
                default: rpm = 16'($urandom);
            endcase
            w = frame_word(rpm);
            if ($urandom_range(0, 9) == 0) begin
                case ($urandom_range(0, 2))
                    0:       w.tag0 = 8'($urandom);
                    1:       w.tag1 = 8'($urandom);
                    default: w.tag2 = 8'($urandom);
                endcase
            end
        end else begin
            w.cmd = gss_pkg::CMD_W'($urandom_range(int'(gss_pkg::CMD_FRAME) + 1,
                                                   (1 << gss_pkg::CMD_W) - 1));
        end
        return w;
    endfunction

    // ---------------- drivers ----------------

    task automatic send_word(input t_word w);
        int unsigned gap;
        gap = pick_gap();
        if (gap != 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid         <= 1'b1;
        i_command       <= w.cmd;
        i_frame_tag0    <= w.tag0;
        i_frame_tag1    <= w.tag1;
        i_frame_tag2    <= w.tag2;
        i_rpm_high_byte <= w.rpm_hi;
        i_rpm_low_byte  <= w.rpm_lo;
        do @(posedge i_clk); while (!o_ready);
        levels_q.push_back(shift_levels(w));
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        while (levels_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // tick until both sequences are back to idle
    task automatic run_out();
        while (up_ph != gss_pkg::UP_IDLE || dn_ph != gss_pkg::DN_IDLE) begin
            send_word(cmd_word(gss_pkg::CMD_TICK));
        end
    endtask

    task automatic reg_write(input logic [2:0] idx, input int unsigned value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            gss_pkg::REG_UP_HOLD:    cfg_m.up_hold_time        = gss_pkg::TIME_W'(value);
            gss_pkg::REG_DN_LEAD:    cfg_m.down_clutch_lead    = gss_pkg::TIME_W'(value);
            gss_pkg::REG_DN_HOLD:    cfg_m.down_hold_time      = gss_pkg::TIME_W'(value);
            gss_pkg::REG_DN_TRAIL:   cfg_m.down_clutch_trail   = gss_pkg::TIME_W'(value);
            gss_pkg::REG_POST_DELAY: cfg_m.post_shift_delay    = gss_pkg::TIME_W'(value);
            gss_pkg::REG_NEUT_EXT:   cfg_m.neutral_extend_time = gss_pkg::TIME_W'(value);
            gss_pkg::REG_AUTO_THR:   cfg_m.auto_up_rpm_hundreds = gss_pkg::TIME_W'(value);
            gss_pkg::REG_ACCEL:      cfg_m.accel_mode          = value[0];
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    task automatic set_timing(input int unsigned up_hold, input int unsigned dn_lead,
                              input int unsigned dn_hold, input int unsigned dn_trail,
                              input int unsigned post, input int unsigned neut_ext,
                              input int unsigned thr, input int unsigned accel);
        run_out();
        drain();
        reg_write(gss_pkg::REG_UP_HOLD, up_hold);
        reg_write(gss_pkg::REG_DN_LEAD, dn_lead);
        reg_write(gss_pkg::REG_DN_HOLD, dn_hold);
        reg_write(gss_pkg::REG_DN_TRAIL, dn_trail);
        reg_write(gss_pkg::REG_POST_DELAY, post);
        reg_write(gss_pkg::REG_NEUT_EXT, neut_ext);
        reg_write(gss_pkg::REG_AUTO_THR, thr);
        reg_write(gss_pkg::REG_ACCEL, accel);
    endtask

    // ---------------- output side ----------------

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else if (sink_hold_req) begin
            sink_hold_req = 1'b0;
            sink_wait     = LONG_HOLD;
            i_ready      <= 1'b0;
        end else if (sink_wait != 0) begin
            sink_wait--;
            i_ready <= 1'b0;
        end else if (!no_gaps && $urandom_range(0, 4) == 0) begin
            sink_wait = pick_gap();
            i_ready  <= (sink_wait == 0);
        end else begin
            i_ready <= 1'b1;
        end
    end

    function automatic void check_field(input string name, input int unsigned want,
                                        input int unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            errors++;
        end
    endfunction

    task automatic reg_check(input string name, input logic [2:0] idx,
                             input int unsigned want);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {idx, 2'b00};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        check_field(name, want, prdata);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin : result_check
        gss_pkg::t_res want;
        if (i_rst_n && o_valid && i_ready) begin
            if (levels_q.size() == 0) begin
                $error("result word with nothing expected");
                errors++;
            end else begin
                want = levels_q.pop_front();
                check_field("up_solenoid", 32'(want.up_solenoid), 32'(o_up_solenoid));
                check_field("down_solenoid", 32'(want.down_solenoid),
                            32'(o_down_solenoid));
                check_field("clutch_valve", 32'(want.clutch_valve), 32'(o_clutch_valve));
                check_field("up_lamp", 32'(want.up_lamp), 32'(o_up_lamp));
                check_field("down_lamp", 32'(want.down_lamp), 32'(o_down_lamp));
                check_field("shift_refused", 32'(want.shift_refused),
                            32'(o_shift_refused));
                check_field("auto_up_fired", 32'(want.auto_up_fired),
                            32'(o_auto_up_fired));
                check_field("engine_rpm", 32'(want.engine_rpm), 32'(o_engine_rpm));
            end
        end
    end

    // ---------------- tests ----------------

    task automatic test_reset_values();
        reg_check("up_hold_time", gss_pkg::REG_UP_HOLD, 32'(cfg_m.up_hold_time));
        reg_check("down_clutch_lead", gss_pkg::REG_DN_LEAD, 32'(cfg_m.down_clutch_lead));
        reg_check("down_hold_time", gss_pkg::REG_DN_HOLD, 32'(cfg_m.down_hold_time));
        reg_check("down_clutch_trail", gss_pkg::REG_DN_TRAIL,
                  32'(cfg_m.down_clutch_trail));
        reg_check("post_shift_delay", gss_pkg::REG_POST_DELAY,
                  32'(cfg_m.post_shift_delay));
        reg_check("neutral_extend_time", gss_pkg::REG_NEUT_EXT,
                  32'(cfg_m.neutral_extend_time));
        reg_check("auto_up_rpm_hundreds", gss_pkg::REG_AUTO_THR,
                  32'(cfg_m.auto_up_rpm_hundreds));
        reg_check("accel_mode", gss_pkg::REG_ACCEL, 32'(cfg_m.accel_mode));
    endtask

    // rpm window edges, bad tags, spare commands, lost requests
    task automatic test_directed();
        t_word w;
        int    c;
        set_timing(4, 3, 3, 2, 2, 2, 20, 0);
        send_word(cmd_word(gss_pkg::CMD_TICK));
        for (c = int'(gss_pkg::CMD_FRAME) + 1; c < (1 << gss_pkg::CMD_W); c++) begin
            w     = random_word();
            w.cmd = gss_pkg::CMD_W'(c);
            send_word(w);
        end
        send_word(cmd_word(gss_pkg::CMD_NEUTRAL));
        w      = frame_word(16'hFFFF);
        w.tag0 = 8'h00;
        send_word(w);
        w      = frame_word(16'hFFFF);
        w.tag1 = 8'hFF;
        send_word(w);
        w      = frame_word(16'hFFFF);
        w.tag2 = gss_pkg::FRAME_TAG1;
        send_word(w);
        send_word(frame_word(16'd300));
        send_word(cmd_word(gss_pkg::CMD_UP));
        send_word(cmd_word(gss_pkg::CMD_DOWN));
        send_word(frame_word(gss_pkg::RPM_LOW_LIMIT));
        send_word(cmd_word(gss_pkg::CMD_UP));
        send_word(frame_word(gss_pkg::RPM_HIGH_LIMIT));
        send_word(cmd_word(gss_pkg::CMD_DOWN));
        send_word(frame_word(gss_pkg::RPM_HIGH_LIMIT + 16'd1));
        send_word(cmd_word(gss_pkg::CMD_UP));
        send_word(cmd_word(gss_pkg::CMD_UP));
        send_word(frame_word(gss_pkg::RPM_LOW_LIMIT - 16'd1));
        send_word(cmd_word(gss_pkg::CMD_DOWN));
        send_word(cmd_word(gss_pkg::CMD_DOWN));
        send_word(frame_word(16'hFFFF));
        send_word(cmd_word(gss_pkg::CMD_TICK));
        run_out();
    endtask

    task automatic test_auto_up();
        set_timing(3, 1, 1, 1, 1, 1, 5, 1);
        send_word(frame_word(16'd501));
        send_word(frame_word(16'd600));
        send_word(frame_word(16'd300));
        set_timing(3, 1, 1, 1, 1, 1, 0, 1);
        send_word(frame_word(16'd0));
        send_word(frame_word(16'd1));
        set_timing(3, 1, 1, 1, 1, 1, 1, 1);
        send_word(frame_word(16'd150));
        send_word(frame_word(16'd101));
        send_word(frame_word(16'd100));
        set_timing(3, 1, 1, 1, 1, 1, 1023, 1);
        send_word(frame_word(16'hFFFF));
        set_timing(3, 1, 1, 1, 1, 1, 0, 0);
        send_word(frame_word(16'hFFFF));
    endtask

    // both hold phases end on one tick with a single neutral event pending
    task automatic test_shared_neutral();
        set_timing(5, 2, 3, 1, 1, 2, 20, 0);
        send_word(frame_word(16'd0));
        send_word(cmd_word(gss_pkg::CMD_NEUTRAL));
        send_word(cmd_word(gss_pkg::CMD_UP));
        send_word(cmd_word(gss_pkg::CMD_DOWN));
        run_out();
    endtask

    // zero-length phases pass through at once; neutral count saturates
    task automatic test_neutral_saturation();
        set_timing(0, 0, 0, 0, 0, 0, 20, 0);
        send_word(frame_word(16'd0));
        send_word(cmd_word(gss_pkg::CMD_UP));
        send_word(cmd_word(gss_pkg::CMD_DOWN));
        repeat (int'(gss_pkg::PEND_MAX) + 3) send_word(cmd_word(gss_pkg::CMD_NEUTRAL));
        set_timing(0, 0, 0, 0, 0, 3, 20, 0);
        repeat (3) begin
            send_word(cmd_word(gss_pkg::CMD_UP));
            run_out();
        end
    endtask

    task automatic test_random();
        int          phase;
        int unsigned span;
        for (phase = 0; phase < 5; phase++) begin
            span = (phase == 4) ? 20 : 6;
            set_timing($urandom_range(0, span), $urandom_range(0, span),
                       $urandom_range(0, span), $urandom_range(0, span),
                       $urandom_range(0, span), $urandom_range(0, span),
                       $urandom_range(0, 12), (phase % 2 == 1) ? 1 : $urandom_range(0, 1));
            repeat (25) send_word(random_word());
        end
    endtask

    // output held off long enough for the block to fill and stall its input
    task automatic test_backpressure();
        set_timing(4, 2, 3, 2, 2, 2, 8, 1);
        sink_hold_req = 1'b1;
        no_gaps       = 1'b1;
        repeat (40) send_word(random_word());
        no_gaps = 1'b0;
        drain();
    endtask

    // largest register values load and count down
    task automatic test_max_times();
        set_timing(1023, 1023, 1023, 1023, 1023, 1023, 1023, 1);
        no_gaps = 1'b1;
        send_word(frame_word(16'd0));
        send_word(cmd_word(gss_pkg::CMD_NEUTRAL));
        send_word(cmd_word(gss_pkg::CMD_UP));
        send_word(cmd_word(gss_pkg::CMD_DOWN));
        repeat (20) send_word(cmd_word(gss_pkg::CMD_TICK));
        no_gaps = 1'b0;
    endtask

    initial begin
        shift_model_reset();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_values();
        test_directed();
        test_auto_up();
        test_shared_neutral();
        test_neutral_saturation();
        test_random();
        test_backpressure();
        test_max_times();
        drain();
        if (errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

// ===== files.f =====
hdl/gss_pkg.sv
hdl/gear_shift_sequencer.sv
tb/tb_gear_shift_sequencer.sv
